// ----- hdl/tbeq_pkg.sv -----
// ----------------------------------------------------------------------------
// tbeq_pkg: shared types and constants of the three-band equalizer
// Register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package tbeq_pkg;

  localparam int STATE_W      = 48;
  localparam int SAMPLE_W     = 32;
  localparam int GAIN_W       = 11;
  localparam int COEF_W       = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MID_GAIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_HP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LP    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MID_HP    = 3'd6;

  localparam logic [GAIN_W-1:0] RST_GAIN    = 11'd100;
  localparam logic [COEF_W-1:0] RST_LOW_LP  = 16'd1865;
  localparam logic [COEF_W-1:0] RST_HIGH_HP = 16'd6674;
  localparam logic [COEF_W-1:0] RST_MID_LP  = 16'd46677;
  localparam logic [COEF_W-1:0] RST_MID_HP  = 16'd296;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } seq_state_t;

endpackage

// ----- hdl/tbeq_serial_mul.sv -----
// ----------------------------------------------------------------------------
// tbeq_serial_mul: bit-serial multiplier, signed multiplicand by unsigned or signed multiplier
// Shifts the multiplier in one bit per cycle and accumulates the product.
// ----------------------------------------------------------------------------
module tbeq_serial_mul
  import tbeq_pkg::*;
#(
  parameter int A_W = 50,
  parameter int B_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [A_W-1:0] a,
  input  logic        [B_W-1:0] b,
  input  logic                 b_signed,
  output logic                 done,
  output logic signed [A_W+B_W-1:0] prod
);

  localparam int CNT_W = $clog2(B_W + 1);

  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic signed [A_W+B_W-1:0] acc;
  logic signed [A_W+B_W-1:0] mcand;
  logic        [B_W-1:0]     mplier;
  logic                      neg;

  // Shift-and-add; for a signed multiplier the top bit carries negative weight.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        cnt    <= '0;
        acc    <= '0;
        mcand  <= (A_W+B_W)'(a);
        mplier <= b;
        neg    <= b_signed;
      end else if (busy) begin
        if (mplier[0]) begin
          if (neg && cnt == CNT_W'(B_W - 1)) acc <= acc - mcand;
          else acc <= acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + 1'b1;
        if (cnt == CNT_W'(B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;

endmodule

// ----- hdl/three_band_audio_equalizer_core.sv -----
// ----------------------------------------------------------------------------
// three_band_audio_equalizer_core: three-band one-pole IIR equalizer
// Low, mid and high band filters sharing one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Each sample passes through seven products on the shared bit-serial multiplier,
// then a restoring division by 100 with one quotient bit per cycle (a quotient
// of 61 minus STATE_FRAC_BITS bits, 45 by default), and is then loaded into the
// result register. A new sample is accepted only while the core is idle, so a
// sample is finished before the next one is taken. The result register holds its
// value until it is taken; a new result waits in the last step while the previous
// one is still held, and the input stalls meanwhile. A set block_start flag clears
// all filter states before its sample is processed.
module three_band_audio_equalizer_core
  import tbeq_pkg::*;
#(
  parameter int STATE_FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SAMPLE_W-1:0]  sample_in,
  input  logic                        block_start,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [SAMPLE_W-1:0]  sample_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data
);

  localparam int MA_W = STATE_W + 2;
  localparam int P_W  = MA_W + COEF_W;
  localparam int ACC_W = STATE_W + GAIN_W + 2;
  localparam int Q_W  = ACC_W - STATE_FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(Q_W + 1);
  localparam int XW_W = STATE_W + SAMPLE_W + 1;
  localparam logic signed [STATE_W-1:0] S_MAX = {1'b0, {(STATE_W-1){1'b1}}};
  localparam logic signed [STATE_W-1:0] S_MIN = {1'b1, {(STATE_W-1){1'b0}}};

  logic signed [GAIN_W-1:0] low_gain, mid_gain, high_gain;
  logic [COEF_W-1:0] low_lp_coef, high_hp_coef, mid_lp_coef, mid_hp_coef;

  logic signed [STATE_W-1:0] low_lp_out, high_hp_out, high_hp_prev_in;
  logic signed [STATE_W-1:0] mid_lp_out, mid_hp_out, mid_hp_prev_in;
  logic signed [STATE_W-1:0] xs;
  logic signed [STATE_W-1:0] lo_v, hi_v, mid_v;
  logic signed [ACC_W-1:0]   acc;

  seq_state_t state, state_next;
  logic [2:0] step;

  logic                  mul_start, mul_done, mul_bsigned;
  logic signed [MA_W-1:0] mul_a;
  logic [COEF_W-1:0]      mul_b;
  logic signed [P_W-1:0]  mul_p;

  logic [Q_W-1:0]   div_num;
  logic [7:0]       div_rem;
  logic             div_neg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic signed [SAMPLE_W-1:0] res;
  logic             res_valid;
  logic             out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_gain     <= RST_GAIN;
      mid_gain     <= RST_GAIN;
      high_gain    <= RST_GAIN;
      low_lp_coef  <= RST_LOW_LP;
      high_hp_coef <= RST_HIGH_HP;
      mid_lp_coef  <= RST_MID_LP;
      mid_hp_coef  <= RST_MID_HP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_LOW_GAIN:  low_gain     <= cfg_data[GAIN_W-1:0];
        REG_MID_GAIN:  mid_gain     <= cfg_data[GAIN_W-1:0];
        REG_HIGH_GAIN: high_gain    <= cfg_data[GAIN_W-1:0];
        REG_LOW_LP:    low_lp_coef  <= cfg_data;
        REG_HIGH_HP:   high_hp_coef <= cfg_data;
        REG_MID_LP:    mid_lp_coef  <= cfg_data;
        REG_MID_HP:    mid_hp_coef  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [STATE_W-1:0] sat(input logic signed [P_W-1:0] v);
    if (v > P_W'(S_MAX)) return S_MAX;
    if (v < P_W'(S_MIN)) return S_MIN;
    return v[STATE_W-1:0];
  endfunction

  tbeq_serial_mul #(.A_W(MA_W), .B_W(COEF_W)) u_mul (
    .clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b),
    .b_signed(mul_bsigned), .done(mul_done), .prod(mul_p)
  );

  // Products: 0 low LP, 1 high HP, 2 mid LP, 3 mid HP, 4..6 band gains.
  always_comb begin
    mul_bsigned = 1'b0;
    mul_a = '0;
    mul_b = '0;
    case (step)
      3'd0: begin mul_a = MA_W'(xs) - MA_W'(low_lp_out); mul_b = low_lp_coef; end
      3'd1: begin
        mul_a = MA_W'(high_hp_out) + MA_W'(xs) - MA_W'(high_hp_prev_in);
        mul_b = high_hp_coef;
      end
      3'd2: begin mul_a = MA_W'(xs) - MA_W'(mid_lp_out); mul_b = mid_lp_coef; end
      3'd3: begin
        mul_a = MA_W'(mid_hp_out) + MA_W'(mid_lp_out) - MA_W'(mid_hp_prev_in);
        mul_b = mid_hp_coef;
      end
      3'd4: begin mul_a = MA_W'(lo_v);  mul_b = COEF_W'(low_gain);  mul_bsigned = 1'b1; end
      3'd5: begin mul_a = MA_W'(mid_v); mul_b = COEF_W'(mid_gain);  mul_bsigned = 1'b1; end
      3'd6: begin mul_a = MA_W'(hi_v);  mul_b = COEF_W'(high_gain); mul_bsigned = 1'b1; end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_valid && !in_stall) state_next = ST_MUL;
      ST_MUL:  if (mul_done && step == 3'd6) state_next = ST_DIV;
      ST_DIV:  if (div_cnt == DIV_CNT_W'(Q_W)) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_free  = !res_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_valid = res_valid;
  assign sample_out = res;

  logic signed [XW_W-1:0] xs_wide;
  logic [8:0] rem_try;
  logic [Q_W-1:0] q_mag;
  assign xs_wide = XW_W'(sample_in) <<< STATE_FRAC_BITS;
  assign rem_try = {div_rem, div_num[Q_W-1]};
  assign q_mag   = div_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      mul_start <= 1'b0;
      res_valid <= 1'b0;
      low_lp_out <= '0; high_hp_out <= '0; high_hp_prev_in <= '0;
      mid_lp_out <= '0; mid_hp_out <= '0; mid_hp_prev_in <= '0;
    end else begin
      state     <= state_next;
      mul_start <= 1'b0;
      if (state == ST_OUT && out_free) res_valid <= 1'b1;
      else if (res_valid && !out_stall) res_valid <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid && !in_stall) begin
          if (xs_wide > XW_W'(S_MAX)) xs <= S_MAX;
          else if (xs_wide < XW_W'(S_MIN)) xs <= S_MIN;
          else xs <= xs_wide[STATE_W-1:0];
          if (block_start) begin
            low_lp_out <= '0; high_hp_out <= '0; high_hp_prev_in <= '0;
            mid_lp_out <= '0; mid_hp_out <= '0; mid_hp_prev_in <= '0;
          end
          step      <= '0;
          acc       <= '0;
          mul_start <= 1'b1;
        end
        ST_MUL: if (mul_done) begin
          case (step)
            3'd0: begin
              lo_v <= sat(P_W'(low_lp_out) + (mul_p >>> COEF_W));
              low_lp_out <= sat(P_W'(low_lp_out) + (mul_p >>> COEF_W));
            end
            3'd1: begin
              hi_v <= sat(mul_p >>> COEF_W);
              high_hp_out <= sat(mul_p >>> COEF_W);
              high_hp_prev_in <= xs;
            end
            3'd2: mid_lp_out <= sat(P_W'(mid_lp_out) + (mul_p >>> COEF_W));
            3'd3: begin
              mid_v <= sat(mul_p >>> COEF_W);
              mid_hp_out <= sat(mul_p >>> COEF_W);
              mid_hp_prev_in <= mid_lp_out;
            end
            default: acc <= acc + ACC_W'(mul_p);
          endcase
          if (step != 3'd6) begin
            step      <= step + 3'd1;
            mul_start <= 1'b1;
          end else begin
            div_neg <= (acc + ACC_W'(mul_p)) < 0;
            div_num <= ((acc + ACC_W'(mul_p)) >>> STATE_FRAC_BITS) < 0 ?
                       Q_W'(-((acc + ACC_W'(mul_p)) >>> STATE_FRAC_BITS)) :
                       Q_W'((acc + ACC_W'(mul_p)) >>> STATE_FRAC_BITS);
            div_rem <= '0;
            div_cnt <= '0;
          end
        end
        ST_DIV: if (div_cnt != DIV_CNT_W'(Q_W)) begin
          // Restoring division: one quotient bit per cycle, quotient
          // bits shift into the low end of the numerator register.
          if (rem_try >= 9'd100) begin
            div_rem <= 8'(rem_try - 9'd100);
            div_num <= {div_num[Q_W-2:0], 1'b1};
          end else begin
            div_rem <= rem_try[7:0];
            div_num <= {div_num[Q_W-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
        end
        ST_OUT: if (out_free) begin
          if (!div_neg) begin
            if (q_mag > Q_W'(32'h7FFF_FFFF)) res <= 32'sh7FFF_FFFF;
            else res <= q_mag[SAMPLE_W-1:0];
          end else begin
            if (q_mag > Q_W'(33'h0_8000_0000)) res <= 32'sh8000_0000;
            else res <= SAMPLE_W'(-q_mag);
          end
        end
        default: ;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall) else $error("accepted while busy");
  a_out_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |=> res_valid) else $error("result not posted");
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |=> $stable(res)) else $error("result changed");

endmodule

// ----- tb/tb_three_band_audio_equalizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_band_audio_equalizer_core: self-checking bench of the equalizer
// Drives a short table of directed samples and then random samples under a
// series of gain and coefficient settings. A bit-true model of the three band
// filters predicts outputs, known table rows give theirs; all compared in order.
// ----------------------------------------------------------------------------
module tb_three_band_audio_equalizer_core;
  import tbeq_pkg::*;

  localparam int FRAC = DEF_FRAC_BITS;
  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -S48_MAX - 1;
  localparam int DRAIN_CYCLES = 250;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clear;
    bit                         known;
    logic signed [SAMPLE_W-1:0] result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample_in = '0;
  logic block_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Model copy of the registers and the filter states.
  longint low_gain_m, mid_gain_m, high_gain_m;
  longint low_lp_a, high_hp_a, mid_lp_a, mid_hp_a;
  longint low_y, high_y, high_x, mid_lp_y, mid_hp_y, mid_hp_x;

  logic signed [SAMPLE_W-1:0] expected_samples[$];
  dir_row_t dir_rows[$];
  int errors = 0;
  int samples_in = 0;
  int samples_out = 0;
  int cfg_writes = 0;
  int clears = 0;
  bit quiet = 1'b0;
  bit long_hold = 1'b0;

  three_band_audio_equalizer_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample_in(sample_in), .block_start(block_start),
    .out_valid(out_valid), .out_stall(out_stall), .sample_out(sample_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic longint sat48(longint v);
    if (v > S48_MAX) return S48_MAX;
    if (v < S48_MIN) return S48_MIN;
    return v;
  endfunction

  // floor(v * a / 2^16), computed wide enough to never overflow.
  function automatic longint coef_mul(longint v, longint a);
    logic signed [79:0] wv, wa, p;
    wv = v;
    wa = a;
    p = wv * wa;
    p = p >>> 16;
    return longint'(p);
  endfunction

  function automatic void eq_clear();
    low_y = 0; high_y = 0; high_x = 0;
    mid_lp_y = 0; mid_hp_y = 0; mid_hp_x = 0;
  endfunction

  function automatic void eq_defaults();
    low_gain_m = 100; mid_gain_m = 100; high_gain_m = 100;
    low_lp_a = RST_LOW_LP; high_hp_a = RST_HIGH_HP;
    mid_lp_a = RST_MID_LP; mid_hp_a = RST_MID_HP;
    eq_clear();
  endfunction

  function automatic void eq_write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    logic signed [GAIN_W-1:0] g;
    g = d[GAIN_W-1:0];
    case (idx)
      REG_LOW_GAIN:  low_gain_m = g;
      REG_MID_GAIN:  mid_gain_m = g;
      REG_HIGH_GAIN: high_gain_m = g;
      REG_LOW_LP:    low_lp_a = d;
      REG_HIGH_HP:   high_hp_a = d;
      REG_MID_LP:    mid_lp_a = d;
      REG_MID_HP:    mid_hp_a = d;
      default: ;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] eq_predict(logic signed [SAMPLE_W-1:0] s,
                                                           logic clr);
    longint xs, lo, hi, mlp, mid, acc, r, xin;
    if (clr) eq_clear();
    xin = s;
    xs = sat48(xin * (64'sd1 <<< FRAC));
    lo = sat48(low_y + coef_mul(xs - low_y, low_lp_a));
    low_y = lo;
    hi = sat48(coef_mul(high_y + xs - high_x, high_hp_a));
    high_y = hi;
    high_x = xs;
    mlp = sat48(mid_lp_y + coef_mul(xs - mid_lp_y, mid_lp_a));
    mid_lp_y = mlp;
    mid = sat48(coef_mul(mid_hp_y + mlp - mid_hp_x, mid_hp_a));
    mid_hp_y = mid;
    mid_hp_x = mlp;
    acc = lo * low_gain_m + mid * mid_gain_m + hi * high_gain_m;
    r = (acc >>> FRAC) / 100;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[SAMPLE_W-1:0];
  endfunction

  // Observes every transaction at the clock edge and keeps the model in step.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] e, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        eq_write_reg(cfg_index, cfg_data);
        cfg_writes++;
      end
      if (in_valid && !in_stall) begin
        e = eq_predict(sample_in, block_start);
        if (samples_in < dir_rows.size() && dir_rows[samples_in].known)
          e = dir_rows[samples_in].result;
        if (block_start) clears++;
        expected_samples.push_back(e);
        samples_in++;
      end
      if (out_valid && !out_stall) begin
        got = sample_out;
        samples_out++;
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected output sample %0d", $time, got);
          errors++;
        end else begin
          e = expected_samples.pop_front();
          if (got !== e) begin
            $display("%0t: sample_out mismatch, expected %0d, actual %0d", $time, e, got);
            errors++;
          end
        end
      end
    end
  end

  // Output side: stalls before each output at random; none when quiet, once long.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 14);
      if (long_hold) begin
        n = 3000;
        long_hold = 1'b0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, logic clr);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_in <= s;
    block_start <= clr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(logic [CFG_DATA_W-1:0] lg, logic [CFG_DATA_W-1:0] mg,
                              logic [CFG_DATA_W-1:0] hg, logic [CFG_DATA_W-1:0] c0,
                              logic [CFG_DATA_W-1:0] c1, logic [CFG_DATA_W-1:0] c2,
                              logic [CFG_DATA_W-1:0] c3);
    reg_write(REG_LOW_GAIN, lg);
    reg_write(REG_MID_GAIN, mg);
    reg_write(REG_HIGH_GAIN, hg);
    reg_write(REG_LOW_LP, c0);
    reg_write(REG_HIGH_HP, c1);
    reg_write(REG_MID_LP, c2);
    reg_write(REG_MID_HP, c3);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(int k);
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed($urandom_range(0, 2000)) - 1000;
      3: return (k % 64 < 32) ? 32'sh4000_0000 : -32'sh4000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(logic signed [SAMPLE_W-1:0] s, logic clr, bit known,
                         logic signed [SAMPLE_W-1:0] r);
    dir_row_t row;
    row.sample = s;
    row.clear = clr;
    row.known = known;
    row.result = r;
    dir_rows.push_back(row);
  endtask

  initial begin
    int phase;
    int k;
    eq_defaults();
    // Silence after reset or a state clear gives silence; the rest follows the filters.
    add_row(32'sd0, 1'b1, 1'b1, 32'sd0);
    add_row(32'sd0, 1'b0, 1'b1, 32'sd0);
    add_row(32'sh7FFF_FFFF, 1'b0, 1'b0, 0);
    add_row(32'sh7FFF_FFFF, 1'b0, 1'b0, 0);
    add_row(32'sh8000_0000, 1'b0, 1'b0, 0);
    add_row(32'sh8000_0000, 1'b0, 1'b0, 0);
    add_row(-32'sd1, 1'b0, 1'b0, 0);
    add_row(32'sd1, 1'b0, 1'b0, 0);
    add_row(32'sh5555_5555, 1'b0, 1'b0, 0);
    add_row(32'shAAAA_AAAA, 1'b0, 1'b0, 0);
    add_row(32'sh7FFF_FFFF, 1'b1, 1'b0, 0);
    add_row(32'sh8000_0000, 1'b0, 1'b0, 0);
    add_row(32'sd0, 1'b1, 1'b1, 32'sd0);
    add_row(32'sd12345, 1'b0, 1'b0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) send_sample(dir_rows[i].sample, dir_rows[i].clear);
    wait_idle();

    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: load_setting(16'd1023, 16'd1023, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: load_setting(16'h0400, 16'h0400, 16'h0400, 16'd0, 16'd0, 16'd0, 16'd0);
        2: load_setting(16'hFC00, 16'h03FF, 16'hF800, 16'hFFFF, 16'd0, 16'hFFFF, 16'd1);
        3: load_setting(16'd0, 16'd0, 16'd0, 16'd1865, 16'd6674, 16'd46677, 16'd296);
        4: begin
          reg_write(3'd7, 16'hFFFF);
          load_setting(16'd100, 16'd100, 16'd100, 16'd1865, 16'd6674, 16'd46677, 16'd296);
        end
        default: load_setting(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      for (k = 0; k < 170; k++) begin
        quiet = (k >= 60 && k < 90);
        if (phase == 5 && k == 100) long_hold = 1'b1;
        send_sample(pick_sample(k), $urandom_range(0, 19) == 0);
      end
      quiet = 1'b0;
      wait_idle();
    end

    $display("Covered %0d samples, %0d output samples, %0d state clears, %0d register writes.",
             samples_in, samples_out, clears, cfg_writes);
    $display("Settings ranged from zero and full-scale coefficients to gain extremes.");
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timeout with %0d output samples still outstanding.", expected_samples.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
